[hw/rtl/lslf_pkg.sv]
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared types and constants for the least-squares line fit unit: channel
// payloads, controller states, datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package lslf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RESULT_W  = 32;
    localparam int FRAC_BITS = 16;

    localparam logic signed [RESULT_W-1:0] RESULT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RESULT_W-1:0] RESULT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_value;
        logic signed [SAMPLE_W-1:0] y_value;
        logic                       last_pair;
    } pair_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] slope;
        logic signed [RESULT_W-1:0] intercept;
        logic                       degenerate;
        logic                       saturated;
    } fit_t;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_MUL_XY,
        ST_DIV_XY,
        ST_MUL_XX,
        ST_DIV_XX,
        ST_TEST,
        ST_DIV_SLOPE,
        ST_MUL_SX,
        ST_DIV_ICPT,
        ST_DONE
    } fit_state_t;

    typedef enum logic [1:0] {
        MUL_XY,
        MUL_XX,
        MUL_SX
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_PROD_N,
        DIV_NUM_DEN,
        DIV_T_N
    } div_op_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_NUM,
        CAP_DEN,
        CAP_SLOPE,
        CAP_T,
        CAP_ICPT
    } cap_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_SIGN
    } unit_phase_t;

    typedef struct packed {
        logic    s1_load;
        logic    acc_en;
        logic    clear_sums;
        logic    mul_start;
        mul_op_t mul_op;
        logic    div_start;
        div_op_t div_op;
        cap_t    cap;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic den_zero;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/least_squares_line_fit_unit.sv]
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit
// Fits y = a + b*x by least squares over a set of (x, y) pairs.
//
// The pair channel takes one pair per transfer (pair_valid high, pair_stall
// low). Ordinary pairs go through a product stage and into the running sums
// at one pair per cycle. A pair with last_pair set closes the set: once it
// has passed the product stage into the sums, the fit runs on one shared
// shift-add multiplier (one bit per cycle) and one shared restoring divider
// (one quotient bit per cycle). pair_stall stays high during the fit; a
// degenerate set stops after the denominator.
// The fit channel carries one result per set from an output register; the
// next set is accepted while that result waits, and a further fit holds in
// its last state until the receiver lifts fit_stall.
// Reset clears the sums and drops any pending result. Pairs beyond MAX_PAIRS
// in one set are left out of the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit_unit
    import lslf_pkg::*;
#(
    parameter int MAX_PAIRS = 4096
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   pair_valid,
    output logic        pair_stall,
    input  wire pair_t  pair,
    output logic        fit_valid,
    input  wire logic   fit_stall,
    output fit_t        fit
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lslf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_last  (pair.last_pair),
        .pair_stall (pair_stall),
        .fit_valid  (fit_valid),
        .fit_stall  (fit_stall),
        .status     (status),
        .cmd        (cmd)
    );

    lslf_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .cmd    (cmd),
        .status (status),
        .fit    (fit)
    );

endmodule

`default_nettype wire

[hw/rtl/lslf_mul.sv]
// ----------------------------------------------------------------------------
// lslf_mul
// Signed shift-and-add multiplier: one bit of operand b per cycle on
// magnitudes, then a final step to apply the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_mul
    import lslf_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 29
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [AW-1:0]    a,
    input  wire logic signed [BW-1:0]    b,
    output logic                         done,
    output logic signed [AW+BW:0]        product
);

    localparam int CNTW = $clog2(BW);

    unit_phase_t              phase_reg, phase_next;
    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]            a_mag_reg, a_mag_next;
    logic [AW+BW-1:0]         acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic                     done_reg, done_next;
    logic signed [AW+BW:0]    product_reg, product_next;

    logic [AW-1:0]            a_u, a_mag;
    logic [BW-1:0]            b_u, b_mag;
    logic [AW:0]              hi_sum;
    logic [AW+BW-1:0]         step_acc;
    logic [AW+BW:0]           ext;

    always_comb
    begin
        a_u      = a;
        b_u      = b;
        a_mag    = a[AW-1] ? (~a_u + AW'(1)) : a_u;
        b_mag    = b[BW-1] ? (~b_u + BW'(1)) : b_u;
        hi_sum   = {1'b0, acc_reg[AW+BW-1:BW]} + {1'b0, a_mag_reg};
        step_acc = acc_reg[0] ? {hi_sum, acc_reg[BW-1:1]} : {1'b0, acc_reg[AW+BW-1:1]};
        ext      = {1'b0, acc_reg};
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        a_mag_next   = a_mag_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        done_next    = 1'b0;
        product_next = product_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_RUN;
                    cnt_next   = CNTW'(BW - 1);
                    a_mag_next = a_mag;
                    acc_next   = {{AW{1'b0}}, b_mag};
                    neg_next   = a[AW-1] ^ b[BW-1];
                end
            end
            PH_RUN:
            begin
                acc_next = step_acc;
                if (cnt_reg == '0)
                begin
                    phase_next = PH_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            PH_SIGN:
            begin
                product_next = neg_reg ? signed'(~ext + 1'b1) : signed'(ext);
                done_next    = 1'b1;
                phase_next   = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg   <= a_mag_next;
        acc_reg     <= acc_next;
        neg_reg     <= neg_next;
        product_reg <= product_next;
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

[hw/rtl/lslf_div.sv]
// ----------------------------------------------------------------------------
// lslf_div
// Signed restoring divider, truncating toward zero: one quotient bit per
// cycle on magnitudes, then a final step to apply the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_div
    import lslf_pkg::*;
#(
    parameter int NDW = 63,
    parameter int DSW = 46
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NDW-1:0]   dividend,
    input  wire logic signed [DSW-1:0]   divisor,
    output logic                         done,
    output logic signed [NDW:0]          quotient
);

    localparam int CNTW = $clog2(NDW);

    unit_phase_t            phase_reg, phase_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [NDW-1:0]         dvd_reg, dvd_next;
    logic [DSW-1:0]         rem_reg, rem_next;
    logic [DSW-1:0]         dsr_reg, dsr_next;
    logic                   neg_reg, neg_next;
    logic                   done_reg, done_next;
    logic signed [NDW:0]    quot_reg, quot_next;

    logic [NDW-1:0]         n_u, n_mag;
    logic [DSW-1:0]         d_u, d_mag;
    logic [DSW:0]           trial, diff;
    logic                   qbit;
    logic [NDW:0]           ext;

    always_comb
    begin
        n_u   = dividend;
        d_u   = divisor;
        n_mag = dividend[NDW-1] ? (~n_u + NDW'(1)) : n_u;
        d_mag = divisor[DSW-1] ? (~d_u + DSW'(1)) : d_u;
        trial = {rem_reg, dvd_reg[NDW-1]};
        diff  = trial - {1'b0, dsr_reg};
        // no borrow means the partial remainder covers the divisor
        qbit  = ~diff[DSW];
        ext   = {1'b0, dvd_reg};
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_RUN;
                    cnt_next   = CNTW'(NDW - 1);
                    dvd_next   = n_mag;
                    rem_next   = '0;
                    dsr_next   = d_mag;
                    neg_next   = dividend[NDW-1] ^ divisor[DSW-1];
                end
            end
            PH_RUN:
            begin
                rem_next = qbit ? diff[DSW-1:0] : trial[DSW-1:0];
                dvd_next = {dvd_reg[NDW-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    phase_next = PH_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            PH_SIGN:
            begin
                quot_next  = neg_reg ? signed'(~ext + 1'b1) : signed'(ext);
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

[hw/rtl/lslf_dp.sv]
// ----------------------------------------------------------------------------
// lslf_dp
// Datapath: product stage, running sums, shared multiplier and divider,
// fit intermediates and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_dp
    import lslf_pkg::*;
#(
    parameter int MAX_PAIRS = 4096
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pair_t      pair,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    output fit_t            fit
);

    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int SW  = SAMPLE_W + CW;
    localparam int PW  = 2 * SAMPLE_W + CW;
    localparam int NW  = PW + 1;
    localparam int MA  = (SW > RESULT_W) ? SW : RESULT_W;
    localparam int PRW = MA + SW + 1;
    localparam int DDW = (PRW + 1 > NW + FRAC_BITS) ? PRW + 1 : NW + FRAC_BITS;
    localparam int DSW = NW;

    // product stage
    logic signed [SAMPLE_W-1:0]   x_s1_reg, x_s1_next;
    logic signed [SAMPLE_W-1:0]   y_s1_reg, y_s1_next;
    logic signed [RESULT_W-1:0]   xx_s1_reg, xx_s1_next;
    logic signed [RESULT_W-1:0]   xy_s1_reg, xy_s1_next;

    // running sums
    logic [CW-1:0]                count_reg, count_next;
    logic signed [SW-1:0]         sum_x_reg, sum_x_next;
    logic signed [SW-1:0]         sum_y_reg, sum_y_next;
    logic signed [PW-1:0]         sum_xx_reg, sum_xx_next;
    logic signed [PW-1:0]         sum_xy_reg, sum_xy_next;

    // fit intermediates
    logic signed [NW-1:0]         num_reg, num_next;
    logic signed [NW-1:0]         den_reg, den_next;
    logic signed [RESULT_W-1:0]   slope_reg, slope_next;
    logic signed [RESULT_W-1:0]   icpt_reg, icpt_next;
    logic signed [DDW-1:0]        t_reg, t_next;
    logic                         sat_reg, sat_next;
    fit_t                         fit_reg, fit_next;

    logic                         count_full;
    logic signed [MA-1:0]         mul_a;
    logic signed [SW-1:0]         mul_b;
    logic                         mul_done;
    logic signed [PRW-1:0]        mul_p;
    logic signed [DDW-1:0]        div_n;
    logic signed [DSW-1:0]        div_d;
    logic                         div_done;
    logic signed [DDW:0]          div_q;
    logic signed [NW+FRAC_BITS-1:0] num_shift;
    logic signed [SW+FRAC_BITS-1:0] sy_shift;
    logic [DDW-RESULT_W+1:0]      q_top;
    logic                         clip_hit;
    logic signed [RESULT_W-1:0]   clip_val;
    logic                         den_zero;

    assign count_full = (count_reg == CW'(MAX_PAIRS));
    assign num_shift  = {num_reg, {FRAC_BITS{1'b0}}};
    assign sy_shift   = {sum_y_reg, {FRAC_BITS{1'b0}}};
    assign den_zero   = (den_reg == '0);

    // saturate the divider result to the 32-bit result range
    always_comb
    begin
        q_top    = div_q[DDW:RESULT_W-1];
        clip_hit = ~((&q_top) | ~(|q_top));
        if (!clip_hit)
        begin
            clip_val = div_q[RESULT_W-1:0];
        end
        else if (div_q[DDW])
        begin
            clip_val = RESULT_MIN;
        end
        else
        begin
            clip_val = RESULT_MAX;
        end
    end

    always_comb
    begin
        case (cmd.mul_op)
            MUL_XY:
            begin
                mul_a = MA'(sum_x_reg);
                mul_b = sum_y_reg;
            end
            MUL_SX:
            begin
                mul_a = MA'(slope_reg);
                mul_b = sum_x_reg;
            end
            default:
            begin
                mul_a = MA'(sum_x_reg);
                mul_b = sum_x_reg;
            end
        endcase
        case (cmd.div_op)
            DIV_NUM_DEN:
            begin
                div_n = DDW'(num_shift);
                div_d = den_reg;
            end
            DIV_T_N:
            begin
                div_n = t_reg;
                div_d = DSW'({1'b0, count_reg});
            end
            default:
            begin
                div_n = DDW'(mul_p);
                div_d = DSW'({1'b0, count_reg});
            end
        endcase
    end

    lslf_mul #(
        .AW (MA),
        .BW (SW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    lslf_div #(
        .NDW (DDW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        x_s1_next  = x_s1_reg;
        y_s1_next  = y_s1_reg;
        xx_s1_next = xx_s1_reg;
        xy_s1_next = xy_s1_reg;
        if (cmd.s1_load)
        begin
            x_s1_next  = pair.x_value;
            y_s1_next  = pair.y_value;
            xx_s1_next = RESULT_W'(pair.x_value) * RESULT_W'(pair.x_value);
            xy_s1_next = RESULT_W'(pair.x_value) * RESULT_W'(pair.y_value);
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xx_next = sum_xx_reg;
        sum_xy_next = sum_xy_reg;
        if (cmd.clear_sums)
        begin
            count_next  = '0;
            sum_x_next  = '0;
            sum_y_next  = '0;
            sum_xx_next = '0;
            sum_xy_next = '0;
        end
        else if (cmd.acc_en && !count_full)
        begin
            count_next  = count_reg + 1'b1;
            sum_x_next  = sum_x_reg + SW'(x_s1_reg);
            sum_y_next  = sum_y_reg + SW'(y_s1_reg);
            sum_xx_next = sum_xx_reg + PW'(xx_s1_reg);
            sum_xy_next = sum_xy_reg + PW'(xy_s1_reg);
        end
    end

    always_comb
    begin
        num_next   = num_reg;
        den_next   = den_reg;
        slope_next = slope_reg;
        icpt_next  = icpt_reg;
        t_next     = t_reg;
        sat_next   = sat_reg;
        case (cmd.cap)
            CAP_NUM:   num_next = NW'(sum_xy_reg) - NW'(div_q);
            CAP_DEN:   den_next = NW'(sum_xx_reg) - NW'(div_q);
            CAP_SLOPE:
            begin
                slope_next = clip_val;
                sat_next   = clip_hit;
            end
            CAP_T:     t_next = DDW'(sy_shift) - DDW'(mul_p);
            CAP_ICPT:
            begin
                icpt_next = clip_val;
                sat_next  = sat_reg | clip_hit;
            end
            default:   ;
        endcase
    end

    always_comb
    begin
        fit_next = fit_reg;
        if (cmd.load_out)
        begin
            fit_next.degenerate = den_zero;
            fit_next.slope      = den_zero ? '0 : slope_reg;
            fit_next.intercept  = den_zero ? '0 : icpt_reg;
            fit_next.saturated  = den_zero ? 1'b0 : sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_xx_reg <= sum_xx_next;
            sum_xy_reg <= sum_xy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_s1_reg  <= x_s1_next;
        y_s1_reg  <= y_s1_next;
        xx_s1_reg <= xx_s1_next;
        xy_s1_reg <= xy_s1_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        slope_reg <= slope_next;
        icpt_reg  <= icpt_next;
        t_reg     <= t_next;
        sat_reg   <= sat_next;
        fit_reg   <= fit_next;
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.den_zero = den_zero;
    assign fit             = fit_reg;

endmodule

`default_nettype wire

[hw/rtl/lslf_ctrl.sv]
// ----------------------------------------------------------------------------
// lslf_ctrl
// Controller: input handshake, product stage valid, fit sequencing over the
// shared multiplier and divider, and the result register valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_ctrl
    import lslf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pair_valid,
    input  wire logic        pair_last,
    output logic             pair_stall,
    output logic             fit_valid,
    input  wire logic        fit_stall,
    input  wire dp_status_t  status,
    output dp_cmd_t          cmd
);

    fit_state_t state_reg, state_next;
    logic       enter_reg, enter_next;
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_last_reg, s1_last_next;
    logic       fit_valid_reg, fit_valid_next;

    logic       accept;
    logic       out_free;

    // hold off new pairs during the fit and while a closing pair is in the product stage
    assign pair_stall = (state_reg != ST_ACCUM) || (s1_valid_reg && s1_last_reg);
    assign accept     = pair_valid && !pair_stall;
    assign out_free   = !fit_valid_reg || !fit_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next = ST_MUL_XY;
                end
            end
            ST_MUL_XY:    if (status.mul_done) state_next = ST_DIV_XY;
            ST_DIV_XY:    if (status.div_done) state_next = ST_MUL_XX;
            ST_MUL_XX:    if (status.mul_done) state_next = ST_DIV_XX;
            ST_DIV_XX:    if (status.div_done) state_next = ST_TEST;
            ST_TEST:      state_next = status.den_zero ? ST_DONE : ST_DIV_SLOPE;
            ST_DIV_SLOPE: if (status.div_done) state_next = ST_MUL_SX;
            ST_MUL_SX:    if (status.mul_done) state_next = ST_DIV_ICPT;
            ST_DIV_ICPT:  if (status.div_done) state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_ACCUM;
            default:      state_next = ST_ACCUM;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = MUL_XY;
        cmd.div_op     = DIV_PROD_N;
        cmd.cap        = CAP_NONE;
        s1_valid_next  = 1'b0;
        s1_last_next   = 1'b0;
        fit_valid_next = fit_valid_reg && fit_stall;
        case (state_reg)
            ST_ACCUM:
            begin
                cmd.s1_load   = accept;
                cmd.acc_en    = s1_valid_reg;
                s1_valid_next = accept;
                s1_last_next  = accept && pair_last;
            end
            ST_MUL_XY:
            begin
                cmd.mul_start = enter_reg;
                cmd.mul_op    = MUL_XY;
            end
            ST_DIV_XY:
            begin
                cmd.div_start = enter_reg;
                cmd.div_op    = DIV_PROD_N;
                cmd.cap       = status.div_done ? CAP_NUM : CAP_NONE;
            end
            ST_MUL_XX:
            begin
                cmd.mul_start = enter_reg;
                cmd.mul_op    = MUL_XX;
            end
            ST_DIV_XX:
            begin
                cmd.div_start = enter_reg;
                cmd.div_op    = DIV_PROD_N;
                cmd.cap       = status.div_done ? CAP_DEN : CAP_NONE;
            end
            ST_DIV_SLOPE:
            begin
                cmd.div_start = enter_reg;
                cmd.div_op    = DIV_NUM_DEN;
                cmd.cap       = status.div_done ? CAP_SLOPE : CAP_NONE;
            end
            ST_MUL_SX:
            begin
                cmd.mul_start = enter_reg;
                cmd.mul_op    = MUL_SX;
                cmd.cap       = status.mul_done ? CAP_T : CAP_NONE;
            end
            ST_DIV_ICPT:
            begin
                cmd.div_start = enter_reg;
                cmd.div_op    = DIV_T_N;
                cmd.cap       = status.div_done ? CAP_ICPT : CAP_NONE;
            end
            ST_DONE:
            begin
                cmd.load_out   = out_free;
                cmd.clear_sums = out_free;
                if (out_free)
                begin
                    fit_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // first cycle in a state launches that state's unit operation
    assign enter_next = (state_next != state_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            enter_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            fit_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enter_reg     <= enter_next;
            s1_valid_reg  <= s1_valid_next;
            s1_last_reg   <= s1_last_next;
            fit_valid_reg <= fit_valid_next;
        end
    end

    assign fit_valid = fit_valid_reg;

endmodule

`default_nettype wire
